/* src/text_compaction_encoder_defines.svh */
// Assertion macros for the text compaction encoder.
// Included by the files that carry concurrent assertions; depends on nothing else.
`ifndef TEXT_COMPACTION_ENCODER_DEFINES_SVH
`define TEXT_COMPACTION_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TCE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tce_pkg.sv */
// Shared constants, types and helper functions of the text compaction encoder.
// Used by the channel interfaces and by every module of the block.
package tce_pkg;

   // Field and datapath widths.
   localparam int COUNT_BITS    = 16;
   localparam int CHAR_BITS     = 8;
   localparam int CW_BITS       = 10;
   localparam int LEN_BITS      = 16;
   localparam int ROW_BITS      = 6;
   localparam int SYM_BITS      = 5;
   localparam int ROW_MAX       = 32;
   localparam int REMAIN_BITS   = 6;
   localparam int DIV_BITS      = COUNT_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
   localparam int WIDE_BITS     = (COUNT_BITS + 1 > LEN_BITS) ? COUNT_BITS + 1 : LEN_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CW_RADIX      = 30;

   typedef logic [SYM_BITS-1:0] sym_type;

   // Symbol and codeword constants.
   localparam sym_type SYM_LATCH_LOWER = 5'd27;
   localparam sym_type SYM_LATCH_SHIFT = 5'd28;
   localparam sym_type SYM_PAD         = 5'd29;
   localparam logic [CW_BITS-1:0] CW_PAD = 10'd900;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

   // Character class boundaries.
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;

   // Register map: index taken from the address bits above the byte offset.
   localparam logic [CSR_ADDR_BITS-3:0] REG_ROW_WIDTH = '0;
   localparam logic [ROW_BITS-1:0]      ROW_RESET     = 6'd3;

   typedef enum logic [1:0] {
      SUB_UPPER = 2'd0,
      SUB_LOWER = 2'd1,
      SUB_DIGIT = 2'd2
   } submode_type;

   // Work handed from the symbolizer to the emitter: up to two codewords.
   typedef struct packed {
      logic [1:0][CW_BITS-1:0] words;
      logic [1:0]              n_words;
      logic                    last;
      logic [COUNT_BITS-1:0]   count;
   } desc_type;

   // Remainder unit request and response.
   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [ROW_BITS-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic                done;
      logic [ROW_BITS-1:0] remainder;
   } rem_rsp_type;

   // Pairs two symbols into one codeword, hi * 30 + lo.
   function automatic logic [CW_BITS-1:0] pack_codeword(input sym_type hi, input sym_type lo);
      return CW_BITS'(hi) * CW_BITS'(CW_RADIX) + CW_BITS'(lo);
   endfunction

endpackage

/* src/tce_if.sv */
// Valid/ready channel interfaces of the text compaction encoder.
// Widths come from tce_pkg.
interface tce_req_if;
   logic                           valid;
   logic                           ready;
   logic [tce_pkg::CHAR_BITS-1:0]  char_code;
   logic                           last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface tce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tce_pkg::CW_BITS-1:0]   codeword;
   logic                          last_word;
   logic [tce_pkg::LEN_BITS-1:0]  length_word;

   modport source (output valid, output codeword, output last_word, output length_word,
                   input ready);
   modport sink   (input valid, input codeword, input last_word, input length_word,
                   output ready);
endinterface

/* src/tce_symbolizer.sv */
// Input register, submode tracking and symbol pairing of the text compaction encoder.
// Depends on tce_pkg and tce_req_if; feeds codeword work to tce_emitter.
module tce_symbolizer (
   input  logic              clock,
   input  logic              reset,
   tce_req_if.sink           req_chan,
   input  logic              desc_take,
   output logic              desc_valid,
   output tce_pkg::desc_type desc
);
   import tce_pkg::*;

   logic                  item_valid_ff, item_valid_in;
   logic [CHAR_BITS-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;
   submode_type           submode_ff, submode_in;
   logic                  half_valid_ff, half_valid_in;
   sym_type               half_sym_ff, half_sym_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  desc_valid_ff, desc_valid_in;
   desc_type              desc_ff, desc_in;

   logic                  desc_free;
   logic                  fire;
   logic                  accept;
   logic                  is_upper;
   logic                  is_lower;
   logic [CHAR_BITS-1:0]  diff_upper;
   logic [CHAR_BITS-1:0]  diff_lower;
   logic [CHAR_BITS-1:0]  diff_digit;
   logic [2:0][SYM_BITS-1:0] ext_sym;
   logic [3:0][SYM_BITS-1:0] cat_sym;
   logic [1:0]            n_sym;
   logic [2:0]            total;
   logic [2:0]            total_pad;
   logic [2:0]            total_m1;
   submode_type           class_sub;
   logic [1:0]            n_words;
   logic [COUNT_BITS:0]   count_sum;
   logic [COUNT_BITS-1:0] count_after;

   // Handshake: the input register drains into the work register.
   assign desc_free      = !desc_valid_ff || desc_take;
   assign fire           = item_valid_ff && desc_free;
   assign req_chan.ready = !item_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;
   assign desc_valid     = desc_valid_ff;
   assign desc           = desc_ff;

   // Character class and raw symbol offsets.
   assign is_upper   = (char_ff >= CHAR_UPPER_A) && (char_ff <= CHAR_UPPER_Z);
   assign is_lower   = (char_ff >= CHAR_LOWER_A) && (char_ff <= CHAR_LOWER_Z);
   assign diff_upper = char_ff - CHAR_UPPER_A;
   assign diff_lower = char_ff - CHAR_LOWER_A;
   assign diff_digit = char_ff - CHAR_ZERO;

   // Latch symbols followed by the character's own symbol; unused slots hold the pad symbol.
   always_comb begin
      ext_sym   = {SYM_PAD, SYM_PAD, SYM_PAD};
      n_sym     = 2'd1;
      class_sub = SUB_DIGIT;
      priority if (is_upper) begin
         class_sub = SUB_UPPER;
         unique case (submode_ff)
            SUB_LOWER: begin
               ext_sym[0] = SYM_LATCH_SHIFT;
               ext_sym[1] = SYM_LATCH_SHIFT;
               ext_sym[2] = diff_upper[SYM_BITS-1:0];
               n_sym      = 2'd3;
            end
            SUB_DIGIT: begin
               ext_sym[0] = SYM_LATCH_SHIFT;
               ext_sym[1] = diff_upper[SYM_BITS-1:0];
               n_sym      = 2'd2;
            end
            default: begin
               ext_sym[0] = diff_upper[SYM_BITS-1:0];
            end
         endcase
      end else if (is_lower) begin
         class_sub = SUB_LOWER;
         if (submode_ff != SUB_LOWER) begin
            ext_sym[0] = SYM_LATCH_LOWER;
            ext_sym[1] = diff_lower[SYM_BITS-1:0];
            n_sym      = 2'd2;
         end else begin
            ext_sym[0] = diff_lower[SYM_BITS-1:0];
         end
      end else begin
         if (submode_ff != SUB_DIGIT) begin
            ext_sym[0] = SYM_LATCH_SHIFT;
            ext_sym[1] = diff_digit[SYM_BITS-1:0];
            n_sym      = 2'd2;
         end else begin
            ext_sym[0] = diff_digit[SYM_BITS-1:0];
         end
      end
   end

   // Put the pending half symbol in front and pair everything up.
   always_comb begin
      if (half_valid_ff) begin
         cat_sym = {ext_sym[2], ext_sym[1], ext_sym[0], half_sym_ff};
      end else begin
         cat_sym = {SYM_PAD, ext_sym[2], ext_sym[1], ext_sym[0]};
      end
      total     = {1'b0, n_sym} + {2'b00, half_valid_ff};
      total_pad = total + {2'b00, last_ff & total[0]};
      total_m1  = total - 3'd1;
      n_words   = total_pad[2:1];
      count_sum = {1'b0, count_ff} + (COUNT_BITS+1)'(n_words);
      if (count_sum[COUNT_BITS]) begin
         count_after = COUNT_MAX;
      end else begin
         count_after = count_sum[COUNT_BITS-1:0];
      end
   end

   // Next state of the input register, the encoder state and the work register.
   always_comb begin
      item_valid_in = item_valid_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      submode_in    = submode_ff;
      half_valid_in = half_valid_ff;
      half_sym_in   = half_sym_ff;
      count_in      = count_ff;
      desc_valid_in = desc_valid_ff;
      desc_in       = desc_ff;
      if (desc_take) begin
         desc_valid_in = 1'b0;
      end
      if (fire) begin
         item_valid_in = 1'b0;
         if (total[0]) begin
            half_sym_in = cat_sym[total_m1[1:0]];
         end
         if (last_ff) begin
            submode_in    = SUB_UPPER;
            half_valid_in = 1'b0;
            count_in      = '0;
         end else begin
            submode_in    = class_sub;
            half_valid_in = total[0];
            count_in      = count_after;
         end
         // A character that only leaves a half symbol produces no work.
         if ((n_words != 2'd0) || last_ff) begin
            desc_valid_in = 1'b1;
         end
         desc_in.words[0] = pack_codeword(cat_sym[0], cat_sym[1]);
         desc_in.words[1] = pack_codeword(cat_sym[2], cat_sym[3]);
         desc_in.n_words  = n_words;
         desc_in.last     = last_ff;
         desc_in.count    = count_after;
      end
      if (accept) begin
         item_valid_in = 1'b1;
         char_in       = req_chan.char_code;
         last_in       = req_chan.last_char;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         submode_ff    <= SUB_UPPER;
         half_valid_ff <= 1'b0;
         half_sym_ff   <= '0;
         count_ff      <= '0;
         desc_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         submode_ff    <= submode_in;
         half_valid_ff <= half_valid_in;
         half_sym_ff   <= half_sym_in;
         count_ff      <= count_in;
         desc_valid_ff <= desc_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      desc_ff <= desc_in;
   end

endmodule

/* src/tce_rem_unit.sv */
// Bit-serial remainder unit: (count + 1) modulo the row width, one dividend bit per cycle.
// Depends on tce_pkg; driven by tce_emitter.
module tce_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  tce_pkg::rem_req_type rem_req,
   output tce_pkg::rem_rsp_type rem_rsp
);
   import tce_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     dividend_ff, dividend_in;
   logic [ROW_BITS-1:0]     divisor_ff, divisor_in;
   logic [ROW_BITS-1:0]     rem_ff, rem_in;
   logic [ROW_BITS-1:0]     shifted;

   // The partial remainder stays below the divisor (at most 32), so it fits in ROW_BITS.
   assign shifted = {rem_ff[ROW_BITS-2:0], dividend_ff[DIV_BITS-1]};

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

   // One restoring step per cycle.
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (rem_req.start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         dividend_in = rem_req.dividend;
         divisor_in  = rem_req.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[DIV_BITS-2:0], 1'b0};
         cnt_in      = cnt_ff + DIV_CNT_BITS'(1);
         if (shifted >= divisor_ff) begin
            rem_in = shifted - divisor_ff;
         end else begin
            rem_in = shifted;
         end
         if (cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

endmodule

/* src/tce_emitter.sv */
// Codeword emitter: sends data codewords, then row padding and the length word.
// Depends on tce_pkg, tce_rsp_if and tce_rem_unit (through its request/response structs).
module tce_emitter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         desc_valid,
   input  tce_pkg::desc_type            desc,
   output logic                         desc_take,
   input  logic [tce_pkg::ROW_BITS-1:0] row_width,
   output tce_pkg::rem_req_type         rem_req,
   input  tce_pkg::rem_rsp_type         rem_rsp,
   tce_rsp_if.source                    rsp_chan
);
   import tce_pkg::*;

   typedef enum logic [2:0] {
      EM_IDLE   = 3'b001,
      EM_DIVIDE = 3'b010,
      EM_EMIT   = 3'b100
   } emit_state_type;

   emit_state_type          state_ff, state_in;
   logic [1:0][CW_BITS-1:0] words_ff, words_in;
   logic [1:0]              n_words_ff, n_words_in;
   logic                    last_ff, last_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [1:0]              sel_ff, sel_in;
   logic [REMAIN_BITS-1:0]  remain_ff, remain_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW_BITS-1:0]      codeword_ff, codeword_in;
   logic                    last_word_ff, last_word_in;
   logic [LEN_BITS-1:0]     length_ff, length_in;

   logic                    out_free;
   logic                    load;
   logic                    final_word;
   logic [CW_BITS-1:0]      push_word;
   logic [ROW_BITS-1:0]     pads;
   logic [REMAIN_BITS-1:0]  remain_total;
   logic [COUNT_BITS:0]     count_sum;
   logic [COUNT_BITS-1:0]   final_count;
   logic [WIDE_BITS-1:0]    len_wide;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign final_word = (remain_ff == REMAIN_BITS'(1));

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.codeword    = codeword_ff;
   assign rsp_chan.last_word   = last_word_ff;
   assign rsp_chan.length_word = length_ff;

   // Data words first, then padding codewords.
   assign push_word = (sel_ff < n_words_ff) ? words_ff[sel_ff[0]] : CW_PAD;

   // Padding count, saturated final count and the length word before it is clamped.
   always_comb begin
      if (rem_rsp.remainder == '0) begin
         pads = '0;
      end else begin
         pads = row_width - rem_rsp.remainder;
      end
      remain_total = REMAIN_BITS'(n_words_ff) + REMAIN_BITS'(pads);
      count_sum    = {1'b0, count_ff} + (COUNT_BITS+1)'(pads);
      if (count_sum[COUNT_BITS]) begin
         final_count = COUNT_MAX;
      end else begin
         final_count = count_sum[COUNT_BITS-1:0];
      end
      len_wide = WIDE_BITS'(final_count) + WIDE_BITS'(1);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      words_in     = words_ff;
      n_words_in   = n_words_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      sel_in       = sel_ff;
      remain_in    = remain_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      codeword_in  = codeword_ff;
      last_word_in = last_word_ff;
      length_in    = length_ff;
      load         = 1'b0;
      desc_take    = 1'b0;

      rem_req.start    = 1'b0;
      rem_req.dividend = DIV_BITS'(desc.count) + DIV_BITS'(1);
      rem_req.divisor  = row_width;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         EM_IDLE: begin
            if (desc_valid) begin
               load = 1'b1;
            end
         end
         EM_DIVIDE: begin
            if (rem_rsp.done) begin
               remain_in = remain_total;
               if (len_wide > WIDE_BITS'(LEN_MAX)) begin
                  len_in = LEN_MAX;
               end else begin
                  len_in = len_wide[LEN_BITS-1:0];
               end
               state_in = (remain_total != '0) ? EM_EMIT : EM_IDLE;
            end
         end
         EM_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               codeword_in  = push_word;
               last_word_in = last_ff && final_word;
               length_in    = (last_ff && final_word) ? len_ff : '0;
               remain_in    = remain_ff - REMAIN_BITS'(1);
               if (sel_ff < n_words_ff) begin
                  sel_in = sel_ff + 2'd1;
               end
               if (final_word) begin
                  state_in = EM_IDLE;
                  if (desc_valid) begin
                     load = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase

      // Take the next transaction's work.
      if (load) begin
         desc_take  = 1'b1;
         words_in   = desc.words;
         n_words_in = desc.n_words;
         last_in    = desc.last;
         count_in   = desc.count;
         sel_in     = '0;
         remain_in  = REMAIN_BITS'(desc.n_words);
         if (desc.last) begin
            rem_req.start = 1'b1;
            state_in      = EM_DIVIDE;
         end else begin
            state_in = EM_EMIT;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         remain_ff    <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      words_ff     <= words_in;
      n_words_ff   <= n_words_in;
      last_ff      <= last_in;
      count_ff     <= count_in;
      len_ff       <= len_in;
      codeword_ff  <= codeword_in;
      last_word_ff <= last_word_in;
      length_ff    <= length_in;
   end

endmodule

/* src/text_compaction_encoder.sv */
// Top level of the text compaction encoder: register port, symbolizer, remainder unit, emitter.
// Depends on tce_pkg, tce_if, tce_symbolizer, tce_rem_unit, tce_emitter and the defines header.
//
// One character enters per transaction on req_chan; codewords leave one per cycle on rsp_chan
// while rsp_chan is ready. A character yields zero, one or two codewords, each passing through
// the output register, and a new character is taken every cycle as long as the codeword stream
// keeps up. The final character of a message adds a bit-serial remainder computation for the
// row padding: COUNT_BITS+1 restoring steps before its first codeword, then up to row_width-1
// padding codewords. The last codeword of a message carries last_word and the length word
// (count+1, saturated). row_width (byte address 0) is written over the APB-style port; the
// user must do so only between messages, which the block itself does not enforce.

`include "text_compaction_encoder_defines.svh"

module text_compaction_encoder (
   input  logic                               clock,
   input  logic                               reset,
   tce_req_if.sink                            req_chan,
   tce_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tce_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tce_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tce_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import tce_pkg::*;

   logic [ROW_BITS-1:0] row_width_ff, row_width_in;
   logic [ROW_BITS-1:0] row_width_eff;
   logic                csr_write;
   logic                desc_valid;
   logic                desc_take;
   desc_type            desc;
   rem_req_type         rem_req;
   rem_rsp_type         rem_rsp;

   // Register port: zero-wait writes, reads of the row width.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_BITS-1:2] == REG_ROW_WIDTH);
   assign prdata    = (paddr[CSR_ADDR_BITS-1:2] == REG_ROW_WIDTH)
                      ? CSR_DATA_BITS'(row_width_ff) : '0;
   assign row_width_in = csr_write ? pwdata[ROW_BITS-1:0] : row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   // Zero acts as one; anything above the maximum acts as the maximum.
   always_comb begin
      if (row_width_ff == '0) begin
         row_width_eff = ROW_BITS'(1);
      end else if (row_width_ff > ROW_BITS'(ROW_MAX)) begin
         row_width_eff = ROW_BITS'(ROW_MAX);
      end else begin
         row_width_eff = row_width_ff;
      end
   end

   tce_symbolizer u_symbolizer (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .desc_take  (desc_take),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   tce_rem_unit u_rem_unit (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   tce_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_take  (desc_take),
      .row_width  (row_width_eff),
      .rem_req    (rem_req),
      .rem_rsp    (rem_rsp),
      .rsp_chan   (rsp_chan)
   );

   // Checks on the codeword stream and on the work hand-off.
   `TCE_ASSERT_IMPLY(a_len_only_on_last, clock, reset,
      rsp_chan.valid && !rsp_chan.last_word, rsp_chan.length_word == '0,
      "length word set on a codeword that is not the last")
   `TCE_ASSERT_IMPLY(a_len_on_last, clock, reset,
      rsp_chan.valid && rsp_chan.last_word, rsp_chan.length_word != '0,
      "last codeword carries no length word")
   `TCE_ASSERT_IMPLY(a_take_needs_work, clock, reset, desc_take, desc_valid,
      "emitter took work that was not there")
   `TCE_ASSERT_NEXT(a_work_holds, clock, reset,
      desc_valid && !desc_take, desc_valid && $stable(desc),
      "pending work changed before the emitter took it")

endmodule
